[src/fkv_pkg.sv]
// Shared constants and types for the FIFO-evicting key-value store.
package fkv_pkg;

    localparam int DEPTH = 16;
    localparam int CAP_WIDTH = 5;
    localparam int OCC_WIDTH = 5;
    localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam int OUT_USER_HIT = 0;
    localparam int OUT_USER_DUP = 1;
    localparam int OUT_USER_WIDTH = 2;

    typedef struct packed {
        logic clear;
        logic evict;
        logic write;
    } fkv_ctrl_t;

endpackage

[src/fifo_evicting_key_value_store.sv]
// Top level of the FIFO-evicting key-value store with stream ports.
// Throughput: one request per cycle unless m_axis_tready stalls the output;
// the input register, one pass of key match and ring update, then the result
// register.
// Reset: all entries invalid, ring empty, capacity 16; a capacity write also
// empties the ring.
module fifo_evicting_key_value_store
    import fkv_pkg::*;
#(
    parameter int KEY_WIDTH = 32,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wen,
    input  logic [CAP_WIDTH-1:0] cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // key, value_in
    input  logic [((KEY_WIDTH+VALUE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    // req_type
    input  logic [0:0]                                   s_axis_tuser,
    output logic                                         m_axis_tvalid,
    input  logic                                         m_axis_tready,
    // value_out, occupancy
    output logic [((VALUE_WIDTH+OCC_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    // hit, duplicate
    output logic [OUT_USER_WIDTH-1:0]                    m_axis_tuser
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int SUM_W  = ((SLOT_W > OCC_WIDTH) ? SLOT_W : OCC_WIDTH) + 1;
    localparam int M_DATA_W = ((VALUE_WIDTH + OCC_WIDTH + 7) / 8) * 8;

    logic                   in_valid_reg, in_valid_next;
    logic                   in_req_reg;
    logic [KEY_WIDTH-1:0]   in_key_reg;
    logic [VALUE_WIDTH-1:0] in_value_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   hit_reg, hit_next;
    logic                   dup_reg, dup_next;
    logic [VALUE_WIDTH-1:0] value_out_reg, value_out_next;
    logic [OCC_WIDTH-1:0]   occ_reg, occ_next;

    logic [CAP_WIDTH-1:0]   capacity_reg, capacity_next;
    logic [SLOT_W-1:0]      oldest_reg, oldest_next;
    logic [OCC_WIDTH-1:0]   count_reg, count_next;

    logic                   advance;
    logic                   fire;
    logic                   s_take;
    logic [OCC_WIDTH-1:0]   eff_cap;
    logic                   full;
    logic [OCC_WIDTH-1:0]   count_after;
    logic [SLOT_W-1:0]      oldest_after;
    logic [SUM_W-1:0]       oldest_inc;
    logic [SUM_W-1:0]       tail_sum;
    logic [SLOT_W-1:0]      tail_slot;
    logic                   match;
    logic [VALUE_WIDTH-1:0] match_value;
    logic                   do_insert;
    fkv_ctrl_t              ctrl;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        priority if (capacity_reg == '0)
        begin
            eff_cap = OCC_WIDTH'(1);
        end
        else if (int'(capacity_reg) > DEPTH)
        begin
            eff_cap = OCC_WIDTH'(DEPTH);
        end
        else
        begin
            eff_cap = capacity_reg;
        end
    end

    always_comb
    begin
        full        = count_reg >= eff_cap;
        oldest_inc  = SUM_W'(oldest_reg) + SUM_W'(1);
        count_after = full ? (eff_cap - OCC_WIDTH'(1)) : count_reg;
        if (!full)
        begin
            oldest_after = oldest_reg;
        end
        else if (oldest_inc == SUM_W'(eff_cap))
        begin
            oldest_after = '0;
        end
        else
        begin
            oldest_after = oldest_inc[SLOT_W-1:0];
        end
        tail_sum = SUM_W'(oldest_after) + SUM_W'(count_after);
        if (tail_sum >= SUM_W'(eff_cap))
        begin
            tail_sum = tail_sum - SUM_W'(eff_cap);
        end
        tail_slot = tail_sum[SLOT_W-1:0];
    end

    assign do_insert  = fire && (in_req_reg == REQ_INSERT) && !match;
    assign ctrl.clear = cfg_wen;
    assign ctrl.evict = do_insert && full;
    assign ctrl.write = do_insert;

    fkv_entries #(
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_entries (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .evict_slot  (oldest_reg),
        .write_slot  (tail_slot),
        .key         (in_key_reg),
        .value_wr    (in_value_reg),
        .match       (match),
        .match_value (match_value)
    );

    always_comb
    begin
        in_valid_next  = s_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
        capacity_next  = capacity_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        hit_next       = hit_reg;
        dup_next       = dup_reg;
        value_out_next = value_out_reg;
        occ_next       = occ_reg;
        if (cfg_wen)
        begin
            capacity_next = cfg_wdata;
            oldest_next   = '0;
            count_next    = '0;
        end
        else if (do_insert)
        begin
            oldest_next = oldest_after;
            count_next  = count_after + OCC_WIDTH'(1);
        end
        if (fire)
        begin
            unique case (in_req_reg)
                REQ_LOOKUP:
                begin
                    hit_next       = match;
                    dup_next       = 1'b0;
                    value_out_next = match ? match_value : '0;
                    occ_next       = count_reg;
                end
                REQ_INSERT:
                begin
                    hit_next       = 1'b0;
                    dup_next       = match;
                    value_out_next = '0;
                    occ_next       = match ? count_reg : (count_after + OCC_WIDTH'(1));
                end
                default:
                begin
                    hit_next       = 1'b0;
                    dup_next       = 1'b0;
                    value_out_next = '0;
                    occ_next       = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            capacity_reg  <= CAP_RESET;
            oldest_reg    <= '0;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            capacity_reg  <= capacity_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_req_reg   <= s_axis_tuser[0];
            in_key_reg   <= s_axis_tdata[KEY_WIDTH-1:0];
            in_value_reg <= s_axis_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
        end
        hit_reg       <= hit_next;
        dup_reg       <= dup_next;
        value_out_reg <= value_out_next;
        occ_reg       <= occ_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_DATA_W'({occ_reg, value_out_reg});

    always_comb
    begin
        m_axis_tuser               = '0;
        m_axis_tuser[OUT_USER_HIT] = hit_reg;
        m_axis_tuser[OUT_USER_DUP] = dup_reg;
    end

endmodule

[src/fkv_entries.sv]
// Entry storage with valid bits, parallel key match and value read.
module fkv_entries
    import fkv_pkg::*;
#(
    parameter int KEY_WIDTH = 32,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  fkv_ctrl_t                ctrl,
    input  logic [$clog2(DEPTH)-1:0] evict_slot,
    input  logic [$clog2(DEPTH)-1:0] write_slot,
    input  logic [KEY_WIDTH-1:0]     key,
    input  logic [VALUE_WIDTH-1:0]   value_wr,
    output logic                     match,
    output logic [VALUE_WIDTH-1:0]   match_value
);

    logic [KEY_WIDTH-1:0]   key_mem_reg   [DEPTH];
    logic [VALUE_WIDTH-1:0] value_mem_reg [DEPTH];
    logic [DEPTH-1:0]       valid_reg;
    logic [DEPTH-1:0]       valid_next;
    logic [DEPTH-1:0]       hit_vec;

    always_comb
    begin
        match_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            hit_vec[i] = valid_reg[i] && (key_mem_reg[i] == key);
            if (hit_vec[i])
            begin
                match_value = match_value | value_mem_reg[i];
            end
        end
        match = |hit_vec;
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = '0;
        end
        else
        begin
            if (ctrl.evict)
            begin
                valid_next[evict_slot] = 1'b0;
            end
            if (ctrl.write)
            begin
                valid_next[write_slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.write && !ctrl.clear)
        begin
            key_mem_reg[write_slot]   <= key;
            value_mem_reg[write_slot] <= value_wr;
        end
    end

endmodule
